### src/qsu_pkg.sv
// Shared types, codes and constants of the quoted string unescaper.
package qsu_pkg;

   // Default width of the line and column counters
   localparam int PositionBits = 16;
   // Width of the reported line and column fields
   localparam int PosOutBits = 16;
   // Entries in the queue between front and back
   localparam int QueueDepth = 4;

   // Item kind codes
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_DATA   = 2'd0;
   localparam kind_type KIND_END    = 2'd1;
   localparam kind_type KIND_REWIND = 2'd2;

   // Error codes
   typedef logic [2:0] err_type;
   localparam err_type ERR_NONE       = 3'd0;
   localparam err_type ERR_NO_OPEN    = 3'd1;
   localparam err_type ERR_BAD_ESCAPE = 3'd2;
   localparam err_type ERR_END_STRING = 3'd3;
   localparam err_type ERR_END_ESCAPE = 3'd4;
   localparam err_type ERR_HALTED     = 3'd5;

   // Character constants
   localparam logic [7:0] CHR_BSLASH  = 8'h5C;
   localparam logic [7:0] CHR_QUOTE   = 8'h22;
   localparam logic [7:0] CHR_APOS    = 8'h27;
   localparam logic [7:0] CHR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHR_CR      = 8'h0D;
   localparam logic [7:0] CHR_TAB     = 8'h09;
   localparam logic [7:0] CHR_NUL     = 8'h00;
   localparam logic [7:0] CHR_LOW_R   = 8'h72;
   localparam logic [7:0] CHR_LOW_N   = 8'h6E;
   localparam logic [7:0] CHR_LOW_T   = 8'h74;
   localparam logic [7:0] CHR_ZERO    = 8'h30;

   // Scanner phase
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_STRING,
      PH_ESCAPE,
      PH_HALTED
   } phase_type;

   // Operation carried from front to back
   typedef enum logic [1:0] {
      OP_BYTE,
      OP_END,
      OP_REWIND,
      OP_NOP
   } op_type;

   // Classified item held in the queue
   typedef struct packed {
      op_type     op;
      logic [7:0] raw;
      logic       is_quote;
      logic       is_bslash;
      logic       is_newline;
      logic       esc_ok;
      logic [7:0] esc_value;
   } token_type;

endpackage

### src/qsu_if.sv
// Handshake channels of the quoted string unescaper.
interface qsu_req_if;
   logic                valid;
   logic                ready;
   qsu_pkg::kind_type   kind;
   logic [7:0]          data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface qsu_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              char_valid;
   logic [7:0]                        char_value;
   logic                              was_escaped;
   logic                              string_end;
   logic [2:0]                        error_code;
   logic [qsu_pkg::PosOutBits-1:0]    line_number;
   logic [qsu_pkg::PosOutBits-1:0]    column_number;

   modport source (output valid, output char_valid, output char_value, output was_escaped,
                   output string_end, output error_code, output line_number,
                   output column_number, input ready);
   modport sink   (input valid, input char_valid, input char_value, input was_escaped,
                   input string_end, input error_code, input line_number,
                   input column_number, output ready);
endinterface

### src/qsu_front.sv
// Front end: accepts input beats and classifies them into tokens.
module qsu_front (
   qsu_req_if.sink             req_bus,
   output logic                push_valid,
   input  logic                push_ready,
   output qsu_pkg::token_type  push_token
);

   // Pass the handshake to the queue
   assign push_valid    = req_bus.valid;
   assign req_bus.ready = push_ready;

   // Classify the beat and decode a possible escape letter
   always_comb begin
      push_token            = '0;
      push_token.raw        = req_bus.data_byte;
      push_token.is_quote   = (req_bus.data_byte == qsu_pkg::CHR_QUOTE);
      push_token.is_bslash  = (req_bus.data_byte == qsu_pkg::CHR_BSLASH);
      push_token.is_newline = (req_bus.data_byte == qsu_pkg::CHR_NEWLINE);

      unique case (req_bus.kind)
         qsu_pkg::KIND_DATA:   push_token.op = qsu_pkg::OP_BYTE;
         qsu_pkg::KIND_END:    push_token.op = qsu_pkg::OP_END;
         qsu_pkg::KIND_REWIND: push_token.op = qsu_pkg::OP_REWIND;
         default:              push_token.op = qsu_pkg::OP_NOP;
      endcase

      push_token.esc_ok = 1'b1;
      case (req_bus.data_byte)
         qsu_pkg::CHR_LOW_R:   push_token.esc_value = qsu_pkg::CHR_CR;
         qsu_pkg::CHR_LOW_N:   push_token.esc_value = qsu_pkg::CHR_NEWLINE;
         qsu_pkg::CHR_NEWLINE: push_token.esc_value = qsu_pkg::CHR_NEWLINE;
         qsu_pkg::CHR_LOW_T:   push_token.esc_value = qsu_pkg::CHR_TAB;
         qsu_pkg::CHR_ZERO:    push_token.esc_value = qsu_pkg::CHR_NUL;
         qsu_pkg::CHR_BSLASH:  push_token.esc_value = qsu_pkg::CHR_BSLASH;
         qsu_pkg::CHR_QUOTE:   push_token.esc_value = qsu_pkg::CHR_QUOTE;
         qsu_pkg::CHR_APOS:    push_token.esc_value = qsu_pkg::CHR_APOS;
         default: begin
            push_token.esc_ok    = 1'b0;
            push_token.esc_value = qsu_pkg::CHR_NUL;
         end
      endcase
   end

endmodule

### src/qsu_queue.sv
// Short token queue between the front and back ends.
module qsu_queue #(
   parameter int DEPTH = qsu_pkg::QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  qsu_pkg::token_type  push_token,
   output logic                pop_valid,
   input  logic                pop_ready,
   output qsu_pkg::token_type  pop_token
);

   localparam int IdxBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntBits = $clog2(DEPTH + 1);
   localparam logic [IdxBits-1:0] LastIdx = IdxBits'(DEPTH - 1);
   localparam logic [CntBits-1:0] FullCnt = CntBits'(DEPTH);

   qsu_pkg::token_type entry_ff [DEPTH];
   logic [IdxBits-1:0] head_ff, head_in;
   logic [IdxBits-1:0] tail_ff, tail_in;
   logic [CntBits-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != FullCnt);
   assign pop_valid  = (count_ff != '0);
   assign pop_token  = entry_ff[head_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and track fill
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == LastIdx) ? '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (head_ff == LastIdx) ? '0 : head_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Store the pushed token
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[tail_ff] <= push_token;
      end
   end

endmodule

### src/qsu_back.sv
// Back end: string scanner, position counters and result register.
module qsu_back #(
   parameter int POSITION_BITS = qsu_pkg::PositionBits
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  qsu_pkg::token_type  pop_token,
   qsu_rsp_if.source           rsp_bus
);

   localparam logic [POSITION_BITS-1:0] PosOne = POSITION_BITS'(1);
   localparam logic [POSITION_BITS-1:0] PosMax = '1;

   qsu_pkg::phase_type         phase_ff, phase_in;
   logic [POSITION_BITS-1:0]   line_ff, line_in;
   logic [POSITION_BITS-1:0]   col_ff, col_in;
   logic                       out_valid_ff;
   logic                       char_valid_ff, char_valid_in;
   logic [7:0]                 char_value_ff, char_value_in;
   logic                       escaped_ff, escaped_in;
   logic                       str_end_ff, str_end_in;
   qsu_pkg::err_type           err_ff, err_in;
   logic [POSITION_BITS-1:0]   line_out_ff, col_out_ff;
   logic                       do_pop, consumed;

   // Take a token when the result register is free or being drained
   assign pop_ready = !out_valid_ff || rsp_bus.ready;
   assign do_pop    = pop_valid && pop_ready;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (do_pop) begin
         unique case (pop_token.op)
            qsu_pkg::OP_REWIND: phase_in = qsu_pkg::PH_IDLE;
            qsu_pkg::OP_END: begin
               if (phase_ff == qsu_pkg::PH_STRING || phase_ff == qsu_pkg::PH_ESCAPE) begin
                  phase_in = qsu_pkg::PH_HALTED;
               end
            end
            qsu_pkg::OP_BYTE: begin
               unique case (phase_ff)
                  qsu_pkg::PH_IDLE: begin
                     phase_in = pop_token.is_quote ? qsu_pkg::PH_STRING
                                                   : qsu_pkg::PH_HALTED;
                  end
                  qsu_pkg::PH_STRING: begin
                     if (pop_token.is_bslash) begin
                        phase_in = qsu_pkg::PH_ESCAPE;
                     end else if (pop_token.is_quote) begin
                        phase_in = qsu_pkg::PH_IDLE;
                     end
                  end
                  qsu_pkg::PH_ESCAPE: begin
                     phase_in = pop_token.esc_ok ? qsu_pkg::PH_STRING
                                                 : qsu_pkg::PH_HALTED;
                  end
                  qsu_pkg::PH_HALTED: phase_in = qsu_pkg::PH_HALTED;
               endcase
            end
            qsu_pkg::OP_NOP: phase_in = phase_ff;
         endcase
      end
   end

   // Result fields and position update; decode only a token that is present
   always_comb begin
      char_valid_in = 1'b0;
      char_value_in = qsu_pkg::CHR_NUL;
      escaped_in    = 1'b0;
      str_end_in    = 1'b0;
      err_in        = qsu_pkg::ERR_NONE;
      consumed      = 1'b0;

      if (pop_valid) begin
         unique case (pop_token.op)
            qsu_pkg::OP_END: begin
               unique case (phase_ff)
                  qsu_pkg::PH_STRING: err_in = qsu_pkg::ERR_END_STRING;
                  qsu_pkg::PH_ESCAPE: err_in = qsu_pkg::ERR_END_ESCAPE;
                  qsu_pkg::PH_HALTED: err_in = qsu_pkg::ERR_HALTED;
                  qsu_pkg::PH_IDLE:   err_in = qsu_pkg::ERR_NONE;
               endcase
            end
            qsu_pkg::OP_BYTE: begin
               unique case (phase_ff)
                  qsu_pkg::PH_IDLE: begin
                     consumed = pop_token.is_quote;
                     if (!pop_token.is_quote) begin
                        err_in = qsu_pkg::ERR_NO_OPEN;
                     end
                  end
                  qsu_pkg::PH_STRING: begin
                     consumed   = 1'b1;
                     str_end_in = pop_token.is_quote;
                     if (!pop_token.is_quote && !pop_token.is_bslash) begin
                        char_valid_in = 1'b1;
                        char_value_in = pop_token.raw;
                     end
                  end
                  qsu_pkg::PH_ESCAPE: begin
                     consumed = pop_token.esc_ok;
                     if (pop_token.esc_ok) begin
                        char_valid_in = 1'b1;
                        char_value_in = pop_token.esc_value;
                        escaped_in    = 1'b1;
                     end else begin
                        err_in = qsu_pkg::ERR_BAD_ESCAPE;
                     end
                  end
                  qsu_pkg::PH_HALTED: err_in = qsu_pkg::ERR_HALTED;
               endcase
            end
            qsu_pkg::OP_REWIND: err_in = qsu_pkg::ERR_NONE;
            qsu_pkg::OP_NOP:    err_in = qsu_pkg::ERR_NONE;
         endcase
      end

      // Move on: rewind returns to line 1 column 1, newline starts a new line, counts saturate
      line_in = line_ff;
      col_in  = col_ff;
      if (pop_token.op == qsu_pkg::OP_REWIND) begin
         line_in = PosOne;
         col_in  = PosOne;
      end else if (consumed) begin
         if (pop_token.is_newline) begin
            if (line_ff != PosMax) begin
               line_in = line_ff + 1'b1;
            end
            col_in = PosOne;
         end else if (col_ff != PosMax) begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= qsu_pkg::PH_IDLE;
         line_ff      <= PosOne;
         col_ff       <= PosOne;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (do_pop) begin
            line_ff      <= line_in;
            col_ff       <= col_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (do_pop) begin
         char_valid_ff <= char_valid_in;
         char_value_ff <= char_value_in;
         escaped_ff    <= escaped_in;
         str_end_ff    <= str_end_in;
         err_ff        <= err_in;
         line_out_ff   <= line_in;
         col_out_ff    <= col_in;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.char_valid    = char_valid_ff;
   assign rsp_bus.char_value    = char_value_ff;
   assign rsp_bus.was_escaped   = escaped_ff;
   assign rsp_bus.string_end    = str_end_ff;
   assign rsp_bus.error_code    = err_ff;
   assign rsp_bus.line_number   = qsu_pkg::PosOutBits'(line_out_ff);
   assign rsp_bus.column_number = qsu_pkg::PosOutBits'(col_out_ff);

endmodule

### src/quoted_string_unescaper.sv
// Top level of the quoted string unescaper.
//
//   channel   direction  payload
//   req_bus   in         kind, data_byte
//   rsp_bus   out        char_valid, char_value, was_escaped, string_end,
//                        error_code, line_number, column_number
//
// One beat in, one beat out; a new beat is taken every cycle while the queue has
// room. With the queue empty, a beat is classified and queued, then the scanner
// loads the result register from it. Throughput is set by the scanner, which
// retires one queued token per cycle while the result register is free or drained.
// Reset empties the queue and result register and returns to line 1 column 1.
// A stalled result holds the scanner; the queue then absorbs up to its depth.
module quoted_string_unescaper #(
   parameter int POSITION_BITS = qsu_pkg::PositionBits,
   parameter int QUEUE_DEPTH   = qsu_pkg::QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   qsu_req_if.sink    req_bus,
   qsu_rsp_if.source  rsp_bus
);

   logic                push_valid, push_ready;
   logic                pop_valid, pop_ready;
   qsu_pkg::token_type  push_token, pop_token;

   // Classify incoming beats
   qsu_front u_front (
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_token (push_token)
   );

   // Decouple front and back
   qsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_token (push_token),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_token  (pop_token)
   );

   // Scan strings and produce results
   qsu_back #(
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_token (pop_token),
      .rsp_bus   (rsp_bus)
   );

endmodule
